FILE: rtl/core/rse_pkg.sv
// Shared types, codes and widths for the randomized set engine.
package rse_pkg;

    localparam int KIND_W   = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int SIZE_W   = 7;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GET    = 2'd2;

    localparam logic [STATUS_W-1:0] RSP_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] RSP_REFUSED = 2'd1;
    localparam logic [STATUS_W-1:0] RSP_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] RSP_EMPTY   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_MOD_WAIT,
        ST_PICK,
        ST_WR_SLOT,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic                capture;
        logic                scan_start;
        logic                scan_step;
        logic                mod_start;
        logic                rd_last;
        logic                rd_pick;
        logic                wr_tail;
        logic                wr_slot;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                load_result;
        logic [STATUS_W-1:0] status;
        logic                pick_data;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              scan_hit;
        logic              scan_done;
        logic              count_zero;
        logic              count_full;
        logic              mod_done;
    } status_t;

endpackage

FILE: rtl/core/rse_in_if.sv
// Request channel: operation kind, value and random number.
interface rse_in_if import rse_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
    logic [DATA_W-1:0]        random_pick;

    modport source (output valid, kind, value, random_pick, input ready);
    modport sink (input valid, kind, value, random_pick, output ready);
endinterface

FILE: rtl/core/rse_out_if.sv
// Response channel: status, picked element and set size.
interface rse_out_if import rse_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] picked_value;
    logic [SIZE_W-1:0]        set_size;

    modport source (output valid, status, picked_value, set_size, input ready);
    modport sink (input valid, status, picked_value, set_size, output ready);
endinterface

FILE: rtl/core/rse_mod.sv
// Iterative restoring remainder unit, one dividend bit per cycle.
module rse_mod import rse_pkg::*;
#(
    parameter int CW = 7
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [CW-1:0]     divisor,
    output logic              done,
    output logic [CW-1:0]     rem
);

    localparam int STEP_W = $clog2(DATA_W + 1);

    logic [CW-1:0]     rem_reg;
    logic [CW-1:0]     rem_next;
    logic [DATA_W-1:0] quo_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [CW:0]       trial;
    logic [CW:0]       diff;

    // The remainder stays below the divisor, so the trial value needs one extra bit.
    assign trial = {rem_reg, quo_reg[DATA_W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        if (trial >= {1'b0, divisor})
        begin
            rem_next = diff[CW-1:0];
        end
        else
        begin
            rem_next = trial[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(DATA_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

FILE: rtl/core/rse_dp.sv
// Datapath: element memory, live count, search pipeline and result registers.
module rse_dp import rse_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output status_t                  sts,
    input  logic [KIND_W-1:0]        in_kind,
    input  logic signed [DATA_W-1:0] in_value,
    input  logic [DATA_W-1:0]        in_pick,
    output logic [STATUS_W-1:0]      out_status,
    output logic signed [DATA_W-1:0] out_picked,
    output logic [SIZE_W-1:0]        out_size
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic [DATA_W-1:0]   mem [CAPACITY];

    logic [KIND_W-1:0]   kind_reg;
    logic [DATA_W-1:0]   value_reg;
    logic [DATA_W-1:0]   pick_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [CW-1:0]       idx_reg;
    logic                pend_v_reg;
    logic [IW-1:0]       pend_idx_reg;
    logic [IW-1:0]       slot_reg;
    logic [DATA_W-1:0]   rd_data_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [DATA_W-1:0]   picked_reg;

    logic [CW-1:0]       count_last;
    logic                scan_live;
    logic                rd_en;
    logic [IW-1:0]       rd_addr;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    logic [DATA_W-1:0]   wr_data;
    logic                mod_done;
    logic [CW-1:0]       mod_rem;

    rse_mod #(.CW(CW)) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mod_start),
        .dividend (pick_reg),
        .divisor  (count_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    assign count_last = count_reg - 1'b1;
    assign scan_live  = idx_reg < count_reg;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (cmd.scan_step && scan_live)
        begin
            rd_en   = 1'b1;
            rd_addr = idx_reg[IW-1:0];
        end
        else if (cmd.rd_last)
        begin
            rd_en   = 1'b1;
            rd_addr = count_last[IW-1:0];
        end
        else if (cmd.rd_pick)
        begin
            rd_en   = 1'b1;
            rd_addr = mod_rem[IW-1:0];
        end
    end

    // The tail entry moves into the freed slot; an insert writes at the tail.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = value_reg;
        if (cmd.wr_tail)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[IW-1:0];
        end
        else if (cmd.wr_slot)
        begin
            wr_en   = 1'b1;
            wr_addr = slot_reg;
            wr_data = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            idx_reg    <= '0;
            pend_v_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.scan_start)
            begin
                idx_reg    <= '0;
                pend_v_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                pend_v_reg <= scan_live;
                if (scan_live)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg  <= in_kind;
            value_reg <= in_value;
            pick_reg  <= in_pick;
        end
        if (cmd.scan_step && scan_live)
        begin
            pend_idx_reg <= idx_reg[IW-1:0];
        end
        if (sts.scan_hit)
        begin
            slot_reg <= pend_idx_reg;
        end
        if (cmd.load_result)
        begin
            status_reg <= cmd.status;
            picked_reg <= cmd.pick_data ? rd_data_reg : '0;
        end
    end

    assign sts.kind       = kind_reg;
    assign sts.scan_hit   = pend_v_reg && (rd_data_reg == value_reg);
    assign sts.scan_done  = !pend_v_reg && !scan_live;
    assign sts.count_zero = count_reg == '0;
    assign sts.count_full = count_reg >= CW'(CAPACITY);
    assign sts.mod_done   = mod_done;

    // The count only changes while a transaction is in flight, so it is stable in the response.
    assign out_status = status_reg;
    assign out_picked = picked_reg;
    assign out_size   = SIZE_W'(count_reg);

endmodule

FILE: rtl/core/rse_ctrl.sv
// Controller state machine that sequences each operation through the datapath.
module rse_ctrl import rse_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    output logic    rsp_valid,
    input  logic    rsp_ready,
    input  status_t sts,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (sts.kind == KIND_INSERT || sts.kind == KIND_REMOVE)
                begin
                    state_next = ST_SCAN;
                end
                else if (sts.kind == KIND_GET && !sts.count_zero)
                begin
                    state_next = ST_MOD_WAIT;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_hit && sts.kind == KIND_REMOVE)
                begin
                    state_next = ST_WR_SLOT;
                end
                else if (sts.scan_hit || sts.scan_done)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_MOD_WAIT:
            begin
                if (sts.mod_done)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                state_next = ST_RESP;
            end
            ST_WR_SLOT:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        rsp_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            ST_DISPATCH:
            begin
                cmd.scan_start = 1'b1;
                if (sts.kind == KIND_GET)
                begin
                    if (sts.count_zero)
                    begin
                        cmd.load_result = 1'b1;
                        cmd.status      = RSP_EMPTY;
                    end
                    else
                    begin
                        cmd.mod_start = 1'b1;
                    end
                end
                else if (sts.kind != KIND_INSERT && sts.kind != KIND_REMOVE)
                begin
                    cmd.load_result = 1'b1;
                    cmd.status      = RSP_REFUSED;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_hit)
                begin
                    if (sts.kind == KIND_REMOVE)
                    begin
                        cmd.rd_last = 1'b1;
                    end
                    else
                    begin
                        cmd.load_result = 1'b1;
                        cmd.status      = RSP_REFUSED;
                    end
                end
                else if (sts.scan_done)
                begin
                    cmd.load_result = 1'b1;
                    if (sts.kind == KIND_REMOVE)
                    begin
                        cmd.status = RSP_REFUSED;
                    end
                    else if (sts.count_full)
                    begin
                        cmd.status = RSP_FULL;
                    end
                    else
                    begin
                        cmd.status  = RSP_DONE;
                        cmd.wr_tail = 1'b1;
                        cmd.cnt_inc = 1'b1;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_MOD_WAIT:
            begin
                cmd.rd_pick = sts.mod_done;
            end
            ST_PICK:
            begin
                cmd.load_result = 1'b1;
                cmd.status      = RSP_DONE;
                cmd.pick_data   = 1'b1;
            end
            ST_WR_SLOT:
            begin
                cmd.wr_slot     = 1'b1;
                cmd.cnt_dec     = 1'b1;
                cmd.load_result = 1'b1;
                cmd.status      = RSP_DONE;
            end
            ST_RESP:
            begin
                rsp_valid = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/core/randomized_set_engine_core.sv
// Sequencing: insert and remove are bounded by the one-entry-per-cycle search of the element
// memory; get random is set by the 32-step remainder unit. Other requests, and a get random on
// an empty set, go from dispatch straight to the response. One transaction is in flight at a
// time and the next request is taken the cycle after the response, so the engine takes no new
// request before the last response is accepted. Reset is asynchronous and active low: the set
// becomes empty at once; memory is not cleared.
module randomized_set_engine_core import rse_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    rse_in_if.sink    req,
    rse_out_if.source rsp
);

    cmd_t    cmd;
    status_t sts;
    logic    req_ready;
    logic    rsp_valid;

    rse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rse_dp #(.CAPACITY(CAPACITY)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_kind    (req.kind),
        .in_value   (req.value),
        .in_pick    (req.random_pick),
        .out_status (rsp.status),
        .out_picked (rsp.picked_value),
        .out_size   (rsp.set_size)
    );

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;

endmodule

FILE: rtl/core/rse_checker.sv
// Port-level checker for the randomized set engine and its bind to the top level.
module rse_checker import rse_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     req_ready,
    input logic                     rsp_valid,
    input logic                     rsp_ready,
    input logic [STATUS_W-1:0]      rsp_status,
    input logic signed [DATA_W-1:0] rsp_picked,
    input logic [SIZE_W-1:0]        rsp_size
);

    // A pending response blocks new requests.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request accepted while a response is pending");

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (CAPACITY > 127) || (int'(rsp_size) <= CAPACITY))
        else $error("set size above capacity");

    a_pick_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != RSP_DONE |-> rsp_picked == '0)
        else $error("picked value nonzero on a failed transaction");

    a_empty_size: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == RSP_EMPTY |-> rsp_size == '0)
        else $error("empty status with a nonzero set size");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_picked) && $stable(rsp_size))
        else $error("stalled response changed");

endmodule

bind randomized_set_engine_core rse_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_picked (rsp.picked_value),
    .rsp_size   (rsp.set_size)
);
